@@ src/assert_macros.svh @@
// Assertion macros shared by the postfix evaluator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge while out of reset.
`define ASSERT_CLKED(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must never be seen at a rising edge while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_CLKED(lbl, clk, rstn, !(cond), msg)

`endif

@@ src/pse_pkg.sv @@
// Package of the postfix evaluator: sizes, token and status codes, and the
// request and response structs of the shared arithmetic unit. No dependencies.
package pse_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned NUM_LETTERS = 52;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned LETTER_W    = 6;
  localparam int unsigned STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VAR_AW      = $clog2(NUM_LETTERS);

  // Token function codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_NUMBER   = 3'd0,
    FN_VARIABLE = 3'd1,
    FN_ADD      = 3'd2,
    FN_SUB      = 3'd3,
    FN_MUL      = 3'd4,
    FN_DIV      = 3'd5,
    FN_END      = 3'd6,
    FN_UNKNOWN  = 3'd7
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_UNDERFLOW  = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_DIV_ZERO   = 3'd3,
    ST_UNKNOWN_OP = 3'd4
  } status_e;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage

@@ src/pse_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// No dependencies; used for the operand stack and the variable table.
module pse_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pse_alu.sv @@
// Shared arithmetic unit: one adder serves add, subtract, shift-add multiply
// and restoring divide with sign correction. Depends on pse_pkg.
`include "assert_macros.svh"

module pse_alu import pse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam int unsigned SUM_W  = WORD_W + 2;
  localparam int unsigned ITER_W = $clog2(WORD_W);

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIX
  } alu_state_e;

  alu_state_e        state_q, state_d;
  alu_op_e           op_q, op_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] x_q, x_d;
  logic [WORD_W-1:0] y_q, y_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic [WORD_W-1:0] result_q, result_d;

  logic [SUM_W-1:0]  add_a, add_b, sum;
  logic              add_sub;
  logic [WORD_W:0]   shifted;
  logic [WORD_W-1:0] a_mag, b_mag;
  logic              qbit;

  // Partial remainder shifted left with the next dividend bit.
  assign shifted = {acc_q, y_q[WORD_W-1]};

  // Magnitudes of the division operands.
  assign a_mag = req_i.a[WORD_W-1] ? (WORD_W'(0) - req_i.a) : req_i.a;
  assign b_mag = req_i.b[WORD_W-1] ? (WORD_W'(0) - req_i.b) : req_i.b;

  // Operand selection for the single shared adder.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        add_a   = {2'b00, req_i.a};
        add_b   = {2'b00, req_i.b};
        add_sub = (req_i.op == ALU_SUB);
      end
      A_RUN: begin
        if (op_q == ALU_DIV) begin
          add_a   = {1'b0, shifted};
          add_b   = {2'b00, x_q};
          add_sub = 1'b1;
        end else begin
          add_a = {2'b00, acc_q};
          add_b = {2'b00, x_q};
        end
      end
      A_FIX: begin
        add_b   = {2'b00, y_q};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    sum = add_a + (add_sub ? ~add_b : add_b) + SUM_W'(add_sub);
  end

  // Sequencer of the iterations.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    acc_d    = acc_q;
    x_d      = x_q;
    y_d      = y_q;
    iter_d   = iter_q;
    neg_d    = neg_q;
    done_d   = 1'b0;
    result_d = result_q;
    qbit     = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d   = req_i.op;
          iter_d = '0;
          acc_d  = '0;
          unique case (req_i.op) inside
            ALU_ADD, ALU_SUB: begin
              result_d = sum[WORD_W-1:0];
              done_d   = 1'b1;
            end
            ALU_MUL: begin
              x_d     = req_i.a;
              y_d     = req_i.b;
              state_d = A_RUN;
            end
            default: begin
              x_d     = b_mag;
              y_d     = a_mag;
              neg_d   = req_i.a[WORD_W-1] ^ req_i.b[WORD_W-1];
              state_d = A_RUN;
            end
          endcase
        end
      end
      A_RUN: begin
        if (op_q == ALU_DIV) begin
          // Restoring step: keep the difference when it does not borrow.
          qbit  = ~sum[SUM_W-1];
          acc_d = qbit ? sum[WORD_W-1:0] : shifted[WORD_W-1:0];
          y_d   = {y_q[WORD_W-2:0], qbit};
        end else begin
          // Shift-add step on the low word of the product.
          if (y_q[0]) begin
            acc_d = sum[WORD_W-1:0];
          end
          x_d = {x_q[WORD_W-2:0], 1'b0};
          y_d = {1'b0, y_q[WORD_W-1:1]};
        end
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(WORD_W - 1)) begin
          if (op_q == ALU_DIV) begin
            state_d = A_FIX;
          end else begin
            result_d = acc_d;
            done_d   = 1'b1;
            state_d  = A_IDLE;
          end
        end
      end
      A_FIX: begin
        // The adder forms the negated quotient when the signs differ.
        result_d = neg_q ? sum[WORD_W-1:0] : y_q;
        done_d   = 1'b1;
        state_d  = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= A_IDLE;
      done_q   <= 1'b0;
      op_q     <= ALU_ADD;
      acc_q    <= '0;
      x_q      <= '0;
      y_q      <= '0;
      iter_q   <= '0;
      neg_q    <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      op_q     <= op_d;
      acc_q    <= acc_d;
      x_q      <= x_d;
      y_q      <= y_d;
      iter_q   <= iter_d;
      neg_q    <= neg_d;
      result_q <= result_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

  `ASSERT_CLKED(a_alu_start_idle, clk_i, rst_ni, req_i.start |-> (state_q == A_IDLE), "ALU started while busy")
  `ASSERT_CLKED(a_alu_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "ALU done held for more than a cycle")
  `ASSERT_NEVER(a_alu_fix_div, clk_i, rst_ni, (state_q == A_FIX) && (op_q != ALU_DIV), "Sign fix outside a divide")

endmodule

@@ src/postfix_stack_evaluator.sv @@
// Postfix expression evaluator, top level; uses pse_pkg, pse_ram and pse_alu.
// Takes one pre-parsed token per input item and returns one result item per
// token. The block accepts one item at a time. Multiply and divide run the
// 32-step shift-add and shift-subtract loop of the shared arithmetic unit;
// the binary operators read their two operands through the single stack
// memory port. A finished result waits in an output register; the next item
// is taken once that register can be loaded.
// Operand stack and variable values live in memories that need no clearing; the
// defined flags are flip-flops cleared by reset and by a successful end token.
`include "assert_macros.svh"

module postfix_stack_evaluator import pse_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [WORD_W-1:0] operand_value_i,
  input  logic [LETTER_W-1:0]      var_letter_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     final_valid_o,
  output logic signed [WORD_W-1:0] final_value_o,
  output logic [STATUS_W-1:0]      status_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_NEXT,
    S_ALU_GO,
    S_ALU_WAIT,
    S_VAR_PUSH,
    S_END_POP,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  func_e                  func_q, func_d;
  logic [WORD_W-1:0]      value_q, value_d;
  logic [LETTER_W-1:0]    letter_q, letter_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [NUM_LETTERS-1:0] defined_q, defined_d;
  logic [WORD_W-1:0]      right_q, right_d;
  logic                   res_fvalid_q, res_fvalid_d;
  logic [WORD_W-1:0]      res_fvalue_q, res_fvalue_d;
  status_e                res_status_q, res_status_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_fvalid_q, out_fvalid_d;
  logic [WORD_W-1:0]      out_fvalue_q, out_fvalue_d;
  status_e                out_status_q, out_status_d;

  logic                   stk_we, stk_re;
  logic [STACK_AW-1:0]    stk_waddr, stk_raddr;
  logic [WORD_W-1:0]      stk_wdata, stk_rdata;
  logic                   var_we, var_re;
  logic [VAR_AW-1:0]      var_addr;
  logic [WORD_W-1:0]      var_rdata;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  logic [CNT_W-1:0]       cnt_m1, cnt_m2;
  logic                   stack_full;
  logic                   letter_ok;

  // Token code to operation of the arithmetic unit.
  function automatic alu_op_e to_alu_op(func_e fn);
    alu_op_e op;
    unique case (fn)
      FN_SUB:  op = ALU_SUB;
      FN_MUL:  op = ALU_MUL;
      FN_DIV:  op = ALU_DIV;
      default: op = ALU_ADD;
    endcase
    return op;
  endfunction

  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign cnt_m2     = cnt_q - CNT_W'(2);
  assign stack_full = (cnt_q == CNT_W'(STACK_DEPTH));
  assign letter_ok  = (letter_q < LETTER_W'(NUM_LETTERS));
  assign var_addr   = letter_q[VAR_AW-1:0];

  // Operand stack memory.
  pse_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Variable value memory.
  pse_ram #(
    .DEPTH (NUM_LETTERS),
    .WIDTH (WORD_W)
  ) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (var_we),
    .waddr_i (var_addr),
    .wdata_i (value_q),
    .re_i    (var_re),
    .raddr_i (var_addr),
    .rdata_o (var_rdata)
  );

  // Shared arithmetic unit.
  pse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Token sequencer.
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    value_d      = value_q;
    letter_d     = letter_q;
    cnt_d        = cnt_q;
    defined_d    = defined_q;
    right_d      = right_q;
    res_fvalid_d = res_fvalid_q;
    res_fvalue_d = res_fvalue_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_fvalid_d = out_fvalid_q;
    out_fvalue_d = out_fvalue_q;
    out_status_d = out_status_q;

    stk_we        = 1'b0;
    stk_waddr     = cnt_q[STACK_AW-1:0];
    stk_wdata     = value_q;
    stk_re        = 1'b0;
    stk_raddr     = cnt_m1[STACK_AW-1:0];
    var_we        = 1'b0;
    var_re        = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = to_alu_op(func_q);
    alu_req.a     = stk_rdata;
    alu_req.b     = right_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d       = func_e'(func_i);
          value_d      = operand_value_i;
          letter_d     = var_letter_i;
          res_fvalid_d = 1'b0;
          res_fvalue_d = '0;
          res_status_d = ST_OK;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        unique case (func_q) inside
          FN_NUMBER: begin
            if (stack_full) begin
              res_status_d = ST_OVERFLOW;
            end else begin
              stk_we = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
            end
          end
          FN_VARIABLE: begin
            if (!letter_ok) begin
              res_status_d = ST_UNKNOWN_OP;
            end else if (stack_full) begin
              res_status_d = ST_OVERFLOW;
            end else if (defined_q[var_addr]) begin
              var_re  = 1'b1;
              state_d = S_VAR_PUSH;
            end else begin
              // First use of the letter stores and pushes the supplied value.
              var_we              = 1'b1;
              defined_d[var_addr] = 1'b1;
              stk_we              = 1'b1;
              cnt_d               = cnt_q + CNT_W'(1);
            end
          end
          FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
            if (cnt_q < CNT_W'(2)) begin
              res_status_d = ST_UNDERFLOW;
            end else begin
              stk_re  = 1'b1;
              state_d = S_RD_NEXT;
            end
          end
          FN_END: begin
            if (cnt_q == '0) begin
              res_status_d = ST_UNDERFLOW;
            end else begin
              stk_re  = 1'b1;
              state_d = S_END_POP;
            end
          end
          default: begin
            res_status_d = ST_UNKNOWN_OP;
          end
        endcase
      end
      S_RD_NEXT: begin
        // Top of stack is the right operand; fetch the left one below it.
        right_d   = stk_rdata;
        stk_re    = 1'b1;
        stk_raddr = cnt_m2[STACK_AW-1:0];
        state_d   = S_ALU_GO;
      end
      S_ALU_GO: begin
        if ((func_q == FN_DIV) && (right_q == '0)) begin
          res_status_d = ST_DIV_ZERO;
          state_d      = S_DONE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_ALU_WAIT;
        end
      end
      S_ALU_WAIT: begin
        if (alu_rsp.done) begin
          stk_we    = 1'b1;
          stk_waddr = cnt_m2[STACK_AW-1:0];
          stk_wdata = alu_rsp.result;
          cnt_d     = cnt_m1;
          state_d   = S_DONE;
        end
      end
      S_VAR_PUSH: begin
        stk_we    = 1'b1;
        stk_wdata = var_rdata;
        cnt_d     = cnt_q + CNT_W'(1);
        state_d   = S_DONE;
      end
      S_END_POP: begin
        res_fvalid_d = 1'b1;
        res_fvalue_d = stk_rdata;
        cnt_d        = '0;
        defined_d    = '0;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_fvalid_d = res_fvalid_q;
          out_fvalue_d = res_fvalue_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      defined_q    <= '0;
      out_valid_q  <= 1'b0;
      func_q       <= FN_NUMBER;
      value_q      <= '0;
      letter_q     <= '0;
      right_q      <= '0;
      res_fvalid_q <= 1'b0;
      res_fvalue_q <= '0;
      res_status_q <= ST_OK;
      out_fvalid_q <= 1'b0;
      out_fvalue_q <= '0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      defined_q    <= defined_d;
      out_valid_q  <= out_valid_d;
      func_q       <= func_d;
      value_q      <= value_d;
      letter_q     <= letter_d;
      right_q      <= right_d;
      res_fvalid_q <= res_fvalid_d;
      res_fvalue_q <= res_fvalue_d;
      res_status_q <= res_status_d;
      out_fvalid_q <= out_fvalid_d;
      out_fvalue_q <= out_fvalue_d;
      out_status_q <= out_status_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign final_valid_o = out_fvalid_q;
  assign final_value_o = out_fvalue_q;
  assign status_o      = out_status_q;

  `ASSERT_CLKED(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(STACK_DEPTH), "Stack count beyond depth")
  `ASSERT_CLKED(a_final_ok, clk_i, rst_ni, (out_valid_q && out_fvalid_q) |-> (out_status_q == ST_OK), "Final value with error status")
  `ASSERT_CLKED(a_end_clears, clk_i, rst_ni, (state_q == S_END_POP) |=> ((cnt_q == '0) && (defined_q == '0)), "End token did not clear state")

endmodule
